>>> sv/nsd_pkg.sv
// Package with phase codes, result kinds and shared types of the PNM stream decoder.
package nsd_pkg;
    localparam logic [3:0] PH_MAGIC_P = 4'd0;
    localparam logic [3:0] PH_MAGIC_D = 4'd1;
    localparam logic [3:0] PH_W_SKIP  = 4'd2;
    localparam logic [3:0] PH_W_DIG   = 4'd3;
    localparam logic [3:0] PH_H_SKIP  = 4'd4;
    localparam logic [3:0] PH_H_DIG   = 4'd5;
    localparam logic [3:0] PH_M_SKIP  = 4'd6;
    localparam logic [3:0] PH_M_DIG   = 4'd7;
    localparam logic [3:0] PH_D_SKIP  = 4'd8;
    localparam logic [3:0] PH_D_DIG   = 4'd9;
    localparam logic [3:0] PH_BIN     = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;
    localparam logic [3:0] PH_ERROR   = 4'd12;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC  = 2'd0;
    localparam logic [1:0] ERR_MAXVAL = 2'd1;
    localparam logic [1:0] ERR_DIM    = 2'd2;

    typedef struct packed {
        logic start;
        logic [15:0] value;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic [7:0] result;
    } t_div_stat;
endpackage

>>> sv/nsd_scaler.sv
// Iterative scaler computing min(255, v*255/maxval) one quotient bit per cycle.
module nsd_scaler
    import nsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_cmd    i_cmd,
    input  logic [15:0] i_maxval,
    output t_div_stat   o_stat
);
    logic [23:0] r_num, n_num;
    logic [16:0] r_rem, n_rem;
    logic [8:0]  r_quo, n_quo;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [15:0] w_den;
    logic [16:0] w_trial;

    assign w_den   = (i_maxval == 16'd0) ? 16'd1 : i_maxval;
    assign w_trial = {r_rem[15:0], r_num[23]};

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_num  = {i_cmd.value, 8'd0} - {8'd0, i_cmd.value};
            n_rem  = 17'd0;
            n_quo  = 9'd0;
            n_cnt  = 5'd24;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[22:0], 1'b0};
            if (w_trial >= {1'b0, w_den}) begin
                n_rem = w_trial - {1'b0, w_den};
                n_quo = (r_quo[8] ? 9'h100 : {r_quo[7:0], 1'b1});
            end else begin
                n_rem = w_trial;
                n_quo = (r_quo[8] ? 9'h100 : {r_quo[7:0], 1'b0});
            end
            if (r_quo[7]) n_quo = 9'h100;
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_stat.busy   = r_busy;
    assign o_stat.done   = r_done;
    assign o_stat.result = r_quo[8] ? 8'hFF : r_quo[7:0];
endmodule

>>> sv/nsd_control.sv
// Parser state machine: header fields, comments, sample assembly, row counting and end-of-image detection.
module nsd_control
    import nsd_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_pixel_byte,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [1:0]  o_depth_code,
    output logic        o_is_binary,
    output logic [1:0]  o_error_code,
    output logic        o_last,
    output t_div_cmd    o_div_cmd,
    output logic [15:0] o_maxval,
    input  t_div_stat   i_div_stat
);
    localparam logic [16:0] DIM_LIM = 17'((1 << DIM_BITS) - 1);

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_fmt, n_fmt;
    logic [DIM_BITS-1:0] r_w, n_w, r_h, n_h;
    logic [15:0] r_max, n_max, r_acc, n_acc;
    logic        r_cmt, n_cmt, r_aft, n_aft;
    logic [17:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_pack, n_pack;
    logic        r_wait, n_wait;
    logic        r_ov, n_ov;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_px, n_px;
    logic [1:0]  r_err, n_err;
    logic        r_last, n_last;
    logic        w_acc_in, w_dig, w_blank, w_pbm;
    logic [19:0] w_mul;
    logic [17:0] w_rowlen;
    logic [16:0] w_dimv;
    logic [DIM_BITS-1:0] w_clip;
    logic [17:0] w_col1;
    logic [15:0] w_row1;

    assign o_in_ready = !r_wait && !r_ov;
    assign w_acc_in   = i_in_valid && o_in_ready;
    assign w_dig      = i_in_byte >= 8'h30 && i_in_byte <= 8'h39;
    assign w_blank    = i_in_byte == 8'h20 || i_in_byte == 8'h09
                     || i_in_byte == 8'h0A || i_in_byte == 8'h0D;
    assign w_mul      = {1'b0, r_acc, 3'd0} + {3'd0, r_acc, 1'b0} + {16'd0, i_in_byte[3:0]};
    assign w_dimv     = {1'b0, r_acc};
    assign w_clip     = (w_dimv > DIM_LIM) ? DIM_LIM[DIM_BITS-1:0] : r_acc[DIM_BITS-1:0];
    assign w_pbm      = r_fmt == 3'd1 || r_fmt == 3'd4;
    assign w_col1     = r_col + 18'd1;
    assign w_row1     = r_row + 16'd1;

    always_comb begin
        if (r_fmt == 3'd3 || r_fmt == 3'd6)
            w_rowlen = 18'({r_w, 1'b0}) + 18'(r_w);
        else if (r_fmt == 3'd4)
            w_rowlen = 18'((18'(r_w) + 18'd7) >> 3);
        else
            w_rowlen = 18'(r_w);
    end

    always_comb begin
        n_phase = r_phase; n_fmt = r_fmt; n_w = r_w; n_h = r_h; n_max = r_max;
        n_acc = r_acc; n_cmt = r_cmt; n_aft = r_aft; n_col = r_col; n_row = r_row;
        n_bit = r_bit; n_pack = r_pack; n_wait = r_wait; n_ov = r_ov;
        n_kind = r_kind; n_px = r_px; n_err = r_err; n_last = r_last;
        o_div_cmd.start = 1'b0;
        o_div_cmd.value = r_acc;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        if (w_acc_in) begin
            case (r_phase)
                PH_MAGIC_P: begin
                    if (i_in_byte != 8'h50) begin
                        n_ov = 1'b1; n_kind = KIND_ERROR; n_err = ERR_MAGIC;
                        n_last = 1'b0; n_phase = PH_ERROR;
                    end else n_phase = PH_MAGIC_D;
                end
                PH_MAGIC_D: begin
                    if (i_in_byte < 8'h31 || i_in_byte > 8'h36) begin
                        n_ov = 1'b1; n_kind = KIND_ERROR; n_err = ERR_MAGIC;
                        n_last = 1'b0; n_phase = PH_ERROR;
                    end else begin
                        n_fmt = i_in_byte[2:0];
                        n_phase = PH_W_SKIP; n_cmt = 1'b0; n_aft = 1'b0;
                    end
                end
                PH_W_SKIP, PH_H_SKIP, PH_M_SKIP, PH_D_SKIP: begin
                    if (r_cmt) begin
                        if (i_in_byte == 8'h0A || i_in_byte == 8'h0D) begin
                            n_cmt = 1'b0; n_aft = 1'b1;
                        end
                    end else if (!r_aft && w_blank) begin
                    end else if (!r_aft && i_in_byte == 8'h23) begin
                        n_cmt = 1'b1;
                    end else begin
                        n_aft = 1'b0;
                        n_acc = w_dig ? {12'd0, i_in_byte[3:0]} : 16'd0;
                        n_phase = r_phase + 4'd1;
                    end
                end
                PH_W_DIG, PH_H_DIG, PH_M_DIG, PH_D_DIG: begin
                    if (w_dig) begin
                        n_acc = (w_mul > 20'hFFFF) ? 16'hFFFF : w_mul[15:0];
                    end else if (r_phase == PH_W_DIG) begin
                        n_w = w_clip; n_phase = PH_H_SKIP;
                    end else if (r_phase == PH_H_DIG) begin
                        n_h = w_clip;
                        if (r_w == '0 || w_clip == '0) begin
                            n_ov = 1'b1; n_kind = KIND_ERROR; n_err = ERR_DIM;
                            n_last = 1'b0; n_phase = PH_ERROR;
                        end else if (w_pbm) begin
                            n_max = 16'd255;
                            n_ov = 1'b1; n_kind = KIND_HEADER; n_last = 1'b0;
                            n_phase = r_fmt[2] ? PH_BIN : PH_D_SKIP;
                            n_col = '0; n_row = '0; n_bit = '0; n_pack = '0;
                        end else n_phase = PH_M_SKIP;
                    end else if (r_phase == PH_M_DIG) begin
                        if (r_acc == 16'd0) begin
                            n_ov = 1'b1; n_kind = KIND_ERROR; n_err = ERR_MAXVAL;
                            n_last = 1'b0; n_phase = PH_ERROR;
                        end else begin
                            n_max = r_acc;
                            n_ov = 1'b1; n_kind = KIND_HEADER; n_last = 1'b0;
                            n_phase = r_fmt[2] ? PH_BIN : PH_D_SKIP;
                            n_col = '0; n_row = '0; n_bit = '0; n_pack = '0;
                        end
                    end else begin
                        n_phase = PH_D_SKIP;
                        o_div_cmd.start = 1'b1;
                        n_wait = 1'b1;
                    end
                end
                PH_BIN: begin
                    o_div_cmd.start = 1'b1;
                    o_div_cmd.value = {8'd0, i_in_byte};
                    n_wait = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (r_wait && i_div_stat.done) begin
            n_wait = 1'b0;
            n_last = 1'b0;
            if (r_fmt == 3'd1) begin
                n_pack = r_pack | ((i_div_stat.result != 8'd0) ? (8'h80 >> r_bit) : 8'h00);
                n_col = w_col1;
                if (r_bit == 3'd7 || w_col1 >= 18'(r_w)) begin
                    n_ov = 1'b1; n_kind = KIND_PIXEL; n_px = n_pack;
                    n_pack = '0; n_bit = '0;
                    if (w_col1 >= w_rowlen) begin
                        n_col = '0; n_row = w_row1;
                        if (w_row1 >= 16'(r_h)) begin
                            n_last = 1'b1; n_phase = PH_DONE;
                        end
                    end
                end else n_bit = r_bit + 3'd1;
            end else begin
                n_ov = 1'b1; n_kind = KIND_PIXEL; n_px = i_div_stat.result;
                n_col = w_col1;
                if (w_col1 >= w_rowlen) begin
                    n_col = '0; n_row = w_row1;
                    if (w_row1 >= 16'(r_h)) begin
                        n_last = 1'b1; n_phase = PH_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC_P; r_fmt <= '0; r_w <= '0; r_h <= '0; r_max <= '0;
            r_acc <= '0; r_cmt <= 1'b0; r_aft <= 1'b0; r_col <= '0; r_row <= '0;
            r_bit <= '0; r_pack <= '0; r_wait <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_phase <= n_phase; r_fmt <= n_fmt; r_w <= n_w; r_h <= n_h; r_max <= n_max;
            r_acc <= n_acc; r_cmt <= n_cmt; r_aft <= n_aft; r_col <= n_col;
            r_row <= n_row; r_bit <= n_bit; r_pack <= n_pack; r_wait <= n_wait;
            r_ov <= n_ov;
        end
        r_kind <= n_kind; r_px <= n_px; r_err <= n_err; r_last <= n_last;
    end

    assign o_maxval       = r_max;
    assign o_out_valid    = r_ov;
    assign o_kind         = r_kind;
    assign o_pixel_byte   = (r_kind == KIND_PIXEL) ? r_px : 8'd0;
    assign o_image_width  = (r_kind == KIND_HEADER) ? 16'(r_w) : 16'd0;
    assign o_image_height = (r_kind == KIND_HEADER) ? 16'(r_h) : 16'd0;
    assign o_depth_code   = (r_kind != KIND_HEADER) ? 2'd0 :
                            (r_fmt == 3'd1 || r_fmt == 3'd4) ? 2'd0 :
                            (r_fmt == 3'd2 || r_fmt == 3'd5) ? 2'd1 : 2'd2;
    assign o_is_binary    = (r_kind == KIND_HEADER) && r_fmt[2];
    assign o_error_code   = (r_kind == KIND_ERROR) ? r_err : 2'd0;
    assign o_last         = (r_kind == KIND_PIXEL) && r_last;
endmodule

>>> sv/netpbm_stream_decoder.sv
// Top level of the byte-serial PNM (P1 to P6) stream decoder.
//  channel | direction | beat payload
//  in      | sink      | i_in_byte
//  out     | source    | o_kind, o_pixel_byte, o_image_width, o_image_height,
//          |           | o_depth_code, o_is_binary, o_error_code, o_last
// Header bytes do not use the scaler; each sample waits until the bit-serial scaler,
// which produces one quotient bit of v*255/maxval per cycle, has finished.
// Reset is synchronous and active low and returns the parser to the magic check.
// A result waits in the output register; the next byte is held off until it is taken.
module netpbm_stream_decoder
    import nsd_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_pixel_byte,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [1:0]  o_depth_code,
    output logic        o_is_binary,
    output logic [1:0]  o_error_code,
    output logic        o_last
);
    t_div_cmd    w_cmd;
    t_div_stat   w_stat;
    logic [15:0] w_maxval;

    nsd_control #(.DIM_BITS(DIM_BITS)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_byte,
        .o_out_valid, .i_out_ready, .o_kind, .o_pixel_byte, .o_image_width,
        .o_image_height, .o_depth_code, .o_is_binary, .o_error_code, .o_last,
        .o_div_cmd(w_cmd), .o_maxval(w_maxval), .i_div_stat(w_stat)
    );

    nsd_scaler u_scale (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_maxval(w_maxval), .o_stat(w_stat)
    );
endmodule

>>> dv/tb_netpbm_stream_decoder.sv
// Testbench for the PNM stream decoder: one ASCII RGB image with a checked result stream.
`timescale 1ns / 1ps

module tb_netpbm_stream_decoder
    import nsd_pkg::*;
();

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pix;
        logic [15:0] w;
        logic [15:0] h;
        logic [1:0]  depth;
        logic        bin;
        logic [1:0]  err;
        logic        last;
    } t_result;

    class pnm_scoreboard;
        t_result     expected_q[$];
        int          mismatches;
        logic [3:0]  phase;
        logic [2:0]  fmt;
        logic [15:0] width_r;
        logic [15:0] height_r;
        logic [15:0] maxval_r;
        logic [15:0] accum;
        logic        in_comment;
        logic        after_cmt;
        logic [17:0] col;
        logic [15:0] row;
        logic [2:0]  bit_idx;
        logic [7:0]  pack;

        function new();
            expected_q = {};
            mismatches = 0;
            phase = PH_MAGIC_P;
            fmt = '0;
            width_r = '0;
            height_r = '0;
            maxval_r = '0;
            accum = '0;
            in_comment = 1'b0;
            after_cmt = 1'b0;
            col = '0;
            row = '0;
            bit_idx = '0;
            pack = '0;
        endfunction

        function bit is_dig(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function logic [7:0] scaled(logic [31:0] v);
            logic [31:0] d;
            logic [31:0] s;
            d = (maxval_r != 0) ? maxval_r : 32'd1;
            s = (v * 32'd255) / d;
            return (s > 32'd255) ? 8'd255 : s[7:0];
        endfunction

        function logic [17:0] row_len();
            if (fmt == 3'd3 || fmt == 3'd6) return width_r * 18'd3;
            if (fmt == 3'd4) return (width_r + 18'd7) / 18'd8;
            return width_r;
        endfunction

        function void push_error(logic [1:0] code);
            t_result r;
            r = '0;
            r.kind = KIND_ERROR;
            r.err = code;
            expected_q.push_back(r);
            phase = PH_ERROR;
        endfunction

        function void push_header();
            t_result r;
            r = '0;
            r.kind = KIND_HEADER;
            r.w = width_r;
            r.h = height_r;
            r.depth = (fmt - 3'd1) % 3;
            r.bin = (fmt >= 3'd4);
            expected_q.push_back(r);
            phase = (fmt >= 3'd4) ? PH_BIN : PH_D_SKIP;
            col = '0;
            row = '0;
            bit_idx = '0;
            pack = '0;
        endfunction

        function void push_pixel(logic [7:0] b, logic [17:0] len);
            t_result r;
            r = '0;
            r.kind = KIND_PIXEL;
            r.pix = b;
            if (col >= len) begin
                col = '0;
                row = row + 16'd1;
                if (row >= height_r) begin
                    r.last = 1'b1;
                    phase = PH_DONE;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void sample_done(logic [15:0] v);
            case (phase)
                PH_W_DIG: begin
                    width_r = v;
                    phase = PH_H_SKIP;
                end
                PH_H_DIG: begin
                    height_r = v;
                    if (width_r == 0 || height_r == 0) begin
                        push_error(ERR_DIM);
                    end else if (fmt == 3'd1 || fmt == 3'd4) begin
                        maxval_r = 16'd255;
                        push_header();
                    end else begin
                        phase = PH_M_SKIP;
                    end
                end
                PH_M_DIG: begin
                    if (v == 0) begin
                        push_error(ERR_MAXVAL);
                    end else begin
                        maxval_r = v;
                        push_header();
                    end
                end
                default: begin
                    phase = PH_D_SKIP;
                    if (fmt == 3'd1) begin
                        if (scaled(v) != 0) pack = pack | (8'h80 >> bit_idx);
                        col = col + 18'd1;
                        if (bit_idx == 3'd7 || col >= width_r) begin
                            push_pixel(pack, width_r);
                            pack = '0;
                            bit_idx = '0;
                        end else begin
                            bit_idx = bit_idx + 3'd1;
                        end
                    end else begin
                        col = col + 18'd1;
                        push_pixel(scaled(v), row_len());
                    end
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] c);
            logic [31:0] n;
            case (phase)
                PH_MAGIC_P: begin
                    if (c != 8'h50) push_error(ERR_MAGIC);
                    else phase = PH_MAGIC_D;
                end
                PH_MAGIC_D: begin
                    if (c < 8'h31 || c > 8'h36) begin
                        push_error(ERR_MAGIC);
                    end else begin
                        fmt = c - 8'h30;
                        phase = PH_W_SKIP;
                        in_comment = 1'b0;
                        after_cmt = 1'b0;
                    end
                end
                PH_W_SKIP, PH_H_SKIP, PH_M_SKIP, PH_D_SKIP: begin
                    if (in_comment) begin
                        if (c == 8'h0A || c == 8'h0D) begin
                            in_comment = 1'b0;
                            after_cmt = 1'b1;
                        end
                    end else if (!after_cmt && (c == 8'h20 || c == 8'h09 ||
                                                c == 8'h0A || c == 8'h0D)) begin
                    end else if (!after_cmt && c == "#") begin
                        in_comment = 1'b1;
                    end else begin
                        after_cmt = 1'b0;
                        accum = is_dig(c) ? c - 8'h30 : 16'd0;
                        phase = phase + 4'd1;
                    end
                end
                PH_W_DIG, PH_H_DIG, PH_M_DIG, PH_D_DIG: begin
                    if (is_dig(c)) begin
                        n = accum * 32'd10 + (c - 8'h30);
                        accum = (n > 32'hFFFF) ? 16'hFFFF : n[15:0];
                    end else begin
                        sample_done(accum);
                    end
                end
                PH_BIN: begin
                    col = col + 18'd1;
                    push_pixel(scaled(c), row_len());
                end
                default: begin
                end
            endcase
        endfunction

        function void check_beat(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected beat: %p", got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
            end
        endfunction
    endclass

    localparam int IMG_W = 2;
    localparam int IMG_H = 32;
    localparam int MAXVAL = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [7:0]  o_pixel_byte;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic [1:0]  o_depth_code;
    logic        o_is_binary;
    logic [1:0]  o_error_code;
    logic        o_last;

    pnm_scoreboard sb;
    logic [7:0]    file_q[$];
    int            sent_count;
    bit            quiet;
    bit            hold_done;

    netpbm_stream_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_pixel_byte   (o_pixel_byte),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_depth_code   (o_depth_code),
        .o_is_binary    (o_is_binary),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
    endtask

    task automatic add_comment();
        int n;
        logic [7:0] c;
        n = $urandom_range(1, 8);
        file_q.push_back("#");
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 255);
            if (c == 8'h0A || c == 8'h0D) c = 8'hA5;
            file_q.push_back(c);
        end
        file_q.push_back(($urandom_range(0, 1) != 0) ? 8'h0A : 8'h0D);
    endtask

    task automatic add_separator();
        logic [7:0] blanks[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
        file_q.push_back(blanks[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0) file_q.push_back(blanks[$urandom_range(0, 3)]);
        if ($urandom_range(0, 15) == 0) begin
            add_comment();
            file_q.push_back("0" + $urandom_range(0, 9));
            file_q.push_back(" ");
        end
    endtask

    task automatic build_file();
        int samples;
        int v;
        add_text("P3\t");
        add_comment();
        add_text($sformatf("%0d  %0d", IMG_W, IMG_H));
        file_q.push_back(8'h0D);
        add_comment();
        add_text($sformatf("%0d\n", MAXVAL));
        // Directed samples: extremes, saturation, a non-digit start and comments.
        add_text("0 1000 255 65535999\tx 1001 ");
        add_text("#\xff\x80\n7 #z\n 3\r");
        samples = 9;
        while (samples < 3 * IMG_W * IMG_H) begin
            case ($urandom_range(0, 9))
                0: v = $urandom_range(1001, 70000);
                1: v = 0;
                2: v = MAXVAL;
                default: v = $urandom_range(0, MAXVAL);
            endcase
            add_text($sformatf("%0d", v));
            add_separator();
            samples++;
        end
        add_text("12 P6 99\n");
    endtask

    task automatic send_byte(logic [7:0] b);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b);
        sent_count++;
    endtask

    initial begin
        int idle;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte = '0;
        sent_count = 0;
        quiet = 1'b0;
        build_file();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (file_q[i]) begin
            quiet = (i > file_q.size() * 85 / 100);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                idle = $urandom_range(1, 12);
                repeat (idle) @(posedge i_clk);
            end
            send_byte(file_q[i]);
        end
        i_in_valid <= 1'b0;
        idle = 0;
        while (sb.expected_q.size() != 0 && idle < 20000) begin
            @(posedge i_clk);
            idle++;
        end
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        int n;
        i_out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && sent_count > 300) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_beat('{o_kind, o_pixel_byte, o_image_width, o_image_height,
                            o_depth_code, o_is_binary, o_error_code, o_last});
        end
    end
endmodule
